[src/longest_match_tokenizer_core_defines.svh]
// Assertion macros shared by the tokenizer modules.
`ifndef LONGEST_MATCH_TOKENIZER_CORE_DEFINES_SVH
`define LONGEST_MATCH_TOKENIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LMT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("failed");
`define LMT_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("failed");
`else
`define LMT_ASSERT(label, prop)
`define LMT_ASSERT_NEVER(label, expr)
`endif
`endif

[src/lmt_pkg.sv]
// Types, constants and match tables for the tokenizer.
package lmt_pkg;
  localparam int MaxTokenLen = 255;
  localparam int NumKw = 17;
  localparam int NumLit = 3;

  typedef enum logic [3:0] {
    K_DELIM = 4'd0, K_KEYWORD = 4'd1, K_NULL = 4'd2, K_INT = 4'd3, K_FLOAT = 4'd4,
    K_STRING = 4'd5, K_BOOL = 4'd6, K_IDENT = 4'd7, K_SPACE = 4'd8, K_EOF = 4'd9,
    K_ERROR = 4'd10
  } kind_t;

  typedef enum logic [3:0] {
    M_IDLE, M_DELIM, M_SPACE, M_WORD, M_UNDERSCORE, M_MINUS, M_ZERO, M_INT,
    M_FLOAT, M_STR_OPEN, M_STR_DONE
  } mode_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] len;
    logic [4:0] kwn;
    logic       bv;
  } tok_t;

  // One accepted character turns into up to two results.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } pair_t;

  localparam logic [NumKw-1:0][71:0] KwText = '{
    {"not_", "equal"}, "    equal", "       lt", "       gt", "      min", "      abs",
    "   divide", " multiply", " subtract", "substring", "  replace", "uppercase",
    "lowercase", "   concat", "     puts", "      set", "      add"};
  localparam logic [NumKw-1:0][3:0] KwLen = '{
    4'd9, 4'd5, 4'd2, 4'd2, 4'd3, 4'd3, 4'd6, 4'd8, 4'd8, 4'd9, 4'd7, 4'd9,
    4'd9, 4'd6, 4'd4, 4'd3, 4'd3};
  localparam logic [NumLit-1:0][39:0] LitText = '{"false", " true", " null"};
  localparam logic [NumLit-1:0][3:0] LitLen = '{4'd5, 4'd4, 4'd4};

  // Character of a left-aligned word at position p, or zero past its end.
  function automatic logic [7:0] word_char(logic [71:0] txt, logic [3:0] n,
                                            logic [7:0] p);
    logic [71:0] sh;
    sh = txt << (8 * (9 - n));
    if (p >= {4'd0, n}) return 8'd0;
    return sh[71 - 8 * p[3:0] -: 8];
  endfunction
endpackage

[src/lmt_scanner.sv]
// Front end: per-character rule matching and token classification.
module lmt_scanner import lmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] c,
  input  logic       eoi,
  output pair_t      res
);
  mode_t            mode_r, mode_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [NumKw-1:0] kw_r, kw_nxt;
  logic [NumLit-1:0] lit_r, lit_nxt;
  logic             err_r, err_nxt;

  logic is_low, is_let, is_dig, is_wrd;
  logic [NumKw-1:0] nk, sk, ek;
  logic [NumLit-1:0] nl, sl;
  logic [4:0] ekn;
  logic has_ek;

  always_comb begin
    is_low = c inside {[8'h61:8'h7a]};
    is_let = is_low || (c inside {[8'h41:8'h5a]});
    is_dig = c inside {[8'h30:8'h39]};
    is_wrd = is_let || is_dig || c == 8'h5f;
    for (int i = 0; i < NumKw; i++) begin
      nk[i] = kw_r[i] && len_r < {4'd0, KwLen[i]} && word_char(KwText[i], KwLen[i], len_r) == c;
      sk[i] = word_char(KwText[i], KwLen[i], 8'd0) == c;
      ek[i] = kw_r[i] && {4'd0, KwLen[i]} == len_r;
    end
    for (int i = 0; i < NumLit; i++) begin
      nl[i] = lit_r[i] && len_r < {4'd0, LitLen[i]} &&
              word_char({32'd0, LitText[i]}, LitLen[i], len_r) == c;
      sl[i] = word_char({32'd0, LitText[i]}, LitLen[i], 8'd0) == c;
    end
    ekn = '0;
    has_ek = |ek;
    for (int i = NumKw - 1; i >= 0; i--) if (ek[i]) ekn = 5'(i);
  end

  function automatic tok_t mk(kind_t k, logic [7:0] n, logic [4:0] w, logic b);
    tok_t t;
    t.kind = k; t.len = n; t.kwn = w; t.bv = b;
    return t;
  endfunction

  always_comb begin
    tok_t fin;
    logic fin_v, do_start, do_ext;
    mode_t ext_mode;
    mode_nxt = mode_r; len_nxt = len_r; kw_nxt = kw_r; lit_nxt = lit_r; err_nxt = err_r;
    res = '0;
    fin_v = 1'b1; fin = '0; do_start = 1'b0; do_ext = 1'b0; ext_mode = mode_r;
    case (mode_r)
      M_DELIM:  fin = mk(K_DELIM, len_r, 5'd0, 1'b0);
      M_SPACE:  fin = mk(K_SPACE, len_r, 5'd0, 1'b0);
      M_ZERO, M_INT: fin = mk(K_INT, len_r, 5'd0, 1'b0);
      M_FLOAT:  fin = mk(K_FLOAT, len_r, 5'd0, 1'b0);
      M_STR_DONE: fin = mk(K_STRING, len_r, 5'd0, 1'b0);
      M_WORD, M_UNDERSCORE: begin
        if (has_ek) fin = mk(K_KEYWORD, len_r, ekn, 1'b0);
        else if (lit_r[0] && len_r == 8'd4) fin = mk(K_NULL, len_r, 5'd0, 1'b0);
        else if (lit_r[1] && len_r == 8'd4) fin = mk(K_BOOL, len_r, 5'd0, 1'b1);
        else if (lit_r[2] && len_r == 8'd5) fin = mk(K_BOOL, len_r, 5'd0, 1'b0);
        else fin = mk(K_IDENT, len_r, 5'd0, 1'b0);
      end
      default: fin_v = 1'b0;
    endcase
    if (eoi) begin
      if (err_r) begin
        res.cnt = 2'd1; res.t0 = mk(K_EOF, 8'd0, 5'd0, 1'b0);
      end else if (mode_r == M_MINUS || mode_r == M_STR_OPEN ||
                   (mode_r == M_UNDERSCORE && !has_ek)) begin
        res.cnt = 2'd2; res.t0 = mk(K_ERROR, 8'd0, 5'd0, 1'b0);
        res.t1 = mk(K_EOF, 8'd0, 5'd0, 1'b0);
      end else if (fin_v) begin
        res.cnt = 2'd2; res.t0 = fin; res.t1 = mk(K_EOF, 8'd0, 5'd0, 1'b0);
      end else begin
        res.cnt = 2'd1; res.t0 = mk(K_EOF, 8'd0, 5'd0, 1'b0);
      end
      mode_nxt = M_IDLE; len_nxt = '0; kw_nxt = '0; lit_nxt = '0; err_nxt = 1'b0;
    end else if (!err_r) begin
      case (mode_r)
        M_IDLE: do_start = 1'b1;
        M_WORD: begin
          if (is_let || |nk || |nl) begin
            kw_nxt = nk; lit_nxt = nl; do_ext = 1'b1;
            ext_mode = is_let ? M_WORD : M_UNDERSCORE;
          end else do_start = 1'b1;
        end
        M_UNDERSCORE: begin
          if (|nk) begin
            kw_nxt = nk; lit_nxt = '0; do_ext = 1'b1; ext_mode = M_UNDERSCORE;
          end else if (has_ek) do_start = 1'b1;
          else begin
            // The "not" prefix goes out as an identifier before the error.
            res.cnt = 2'd2; res.t0 = mk(K_IDENT, 8'd3, 5'd0, 1'b0);
            res.t1 = mk(K_ERROR, 8'd0, 5'd0, 1'b0);
            err_nxt = 1'b1; mode_nxt = M_IDLE; len_nxt = '0; kw_nxt = '0; lit_nxt = '0;
          end
        end
        M_MINUS: begin
          if (c inside {[8'h31:8'h39]}) begin do_ext = 1'b1; ext_mode = M_INT; end
          else begin
            res.cnt = 2'd1; res.t0 = mk(K_ERROR, 8'd0, 5'd0, 1'b0);
            err_nxt = 1'b1; mode_nxt = M_IDLE; len_nxt = '0;
          end
        end
        M_ZERO: if (c == 8'h2e) begin do_ext = 1'b1; ext_mode = M_FLOAT; end
                else do_start = 1'b1;
        M_INT: begin
          if (is_dig) begin do_ext = 1'b1; ext_mode = M_INT; end
          else if (c == 8'h2e) begin do_ext = 1'b1; ext_mode = M_FLOAT; end
          else do_start = 1'b1;
        end
        M_FLOAT: if (is_dig) begin do_ext = 1'b1; ext_mode = M_FLOAT; end
                 else do_start = 1'b1;
        M_STR_OPEN: begin
          if (is_wrd) begin do_ext = 1'b1; ext_mode = M_STR_OPEN; end
          else if (c == 8'h22) begin do_ext = 1'b1; ext_mode = M_STR_DONE; end
          else begin
            res.cnt = 2'd1; res.t0 = mk(K_ERROR, 8'd0, 5'd0, 1'b0);
            err_nxt = 1'b1; mode_nxt = M_IDLE; len_nxt = '0;
          end
        end
        default: do_start = 1'b1;
      endcase
      if (do_ext) begin
        if ({24'd0, len_r} >= MaxTokenLen) begin
          res.cnt = 2'd1; res.t0 = mk(K_ERROR, 8'd0, 5'd0, 1'b0);
          err_nxt = 1'b1; mode_nxt = M_IDLE; len_nxt = '0; kw_nxt = '0; lit_nxt = '0;
        end else begin
          len_nxt = len_r + 8'd1; mode_nxt = ext_mode;
        end
      end
      if (do_start) begin
        if (fin_v) begin res.cnt = 2'd1; res.t0 = fin; end
        len_nxt = 8'd1; kw_nxt = '0; lit_nxt = '0;
        if (c == 8'h28 || c == 8'h29) mode_nxt = M_DELIM;
        else if (c == 8'h20 || c == 8'h0a) mode_nxt = M_SPACE;
        else if (is_low) begin mode_nxt = M_WORD; kw_nxt = sk; lit_nxt = sl; end
        else if (c == 8'h2d) mode_nxt = M_MINUS;
        else if (c == 8'h30) mode_nxt = M_ZERO;
        else if (is_dig) mode_nxt = M_INT;
        else if (c == 8'h22) mode_nxt = M_STR_OPEN;
        else begin
          mode_nxt = M_IDLE; len_nxt = '0; err_nxt = 1'b1;
          if (fin_v) begin res.cnt = 2'd2; res.t1 = mk(K_ERROR, 8'd0, 5'd0, 1'b0); end
          else begin res.cnt = 2'd1; res.t0 = mk(K_ERROR, 8'd0, 5'd0, 1'b0); end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; len_r <= '0; kw_r <= '0; lit_r <= '0; err_r <= 1'b0;
    end else if (take) begin
      mode_r <= mode_nxt; len_r <= len_nxt; kw_r <= kw_nxt; lit_r <= lit_nxt;
      err_r <= err_nxt;
    end
  end
endmodule

[src/lmt_queue.sv]
// Short queue of result pairs between the scanner and the output sequencer.
module lmt_queue import lmt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  pair_t din,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output pair_t dout
);
`include "longest_match_tokenizer_core_defines.svh"
  pair_t      mem [4];
  logic [2:0] wp_r, rp_r;

  assign full  = (wp_r[1:0] == rp_r[1:0]) && (wp_r[2] != rp_r[2]);
  assign empty = wp_r == rp_r;
  assign dout  = mem[rp_r[1:0]];

  always_ff @(posedge clk) if (push) mem[wp_r[1:0]] <= din;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 3'd1;
      if (pop) rp_r <= rp_r + 3'd1;
    end
  end

  `LMT_ASSERT_NEVER(a_no_overflow, push && full && !pop)
  `LMT_ASSERT_NEVER(a_no_underflow, pop && empty)
  `LMT_ASSERT(a_count_ok, (wp_r - rp_r) <= 3'd4)
endmodule

[src/lmt_emitter.sv]
// Back end: delivers one or two results per queued entry through an output register.
module lmt_emitter import lmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  pair_t      q_dout,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_token_kind,
  output logic [7:0] out_token_length,
  output logic [4:0] out_keyword_number,
  output logic       out_bool_value,
  output logic       out_last_of_run
);
`include "longest_match_tokenizer_core_defines.svh"
  logic sel_r, sel_nxt, v_r;
  tok_t cur;
  logic last, load;

  assign cur  = sel_r ? q_dout.t1 : q_dout.t0;
  assign last = sel_r || q_dout.cnt == 2'd1;
  assign load = !q_empty && (!v_r || !out_stall);
  assign q_pop = load && last;
  assign sel_nxt = load ? !last : sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0; sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) v_r <= 1'b1;
      else if (!out_stall) v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_token_kind <= cur.kind; out_token_length <= cur.len;
      out_keyword_number <= cur.kwn; out_bool_value <= cur.bv;
      out_last_of_run <= last;
    end
  end
  assign out_valid = v_r;

  `LMT_ASSERT(a_hold, out_valid && out_stall |=> $stable(out_token_kind))
  `LMT_ASSERT_NEVER(a_sel_empty, sel_r && q_empty)
  `LMT_ASSERT(a_second, sel_r && load |-> q_dout.cnt == 2'd2)
endmodule

[src/longest_match_tokenizer_core.sv]
// Top level of the longest-match tokenizer.
// A result passes through the queue and then the output register once its token ends.
// Throughput: one character per cycle while the queue is not full; a character that
// causes two results emits them one after the other; a four-entry queue absorbs this.
// Reset (rst_n low, synchronous) clears scan state, the error latch and the queue.
module longest_match_tokenizer_core import lmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_token_kind,
  output logic [7:0] out_token_length,
  output logic [4:0] out_keyword_number,
  output logic       out_bool_value,
  output logic       out_last_of_run
);
  pair_t res, q_dout;
  logic  take, full, empty, pop;

  // Stall is registered queue state only, never in_valid.
  assign in_stall = full;
  assign take = in_valid && !full;

  lmt_scanner u_scan (.clk, .rst_n, .take, .c(in_char_code), .eoi(in_end_of_input), .res);
  lmt_queue u_q (.clk, .rst_n, .push(take && res.cnt != 2'd0), .din(res), .full,
                 .pop, .empty, .dout(q_dout));
  lmt_emitter u_emit (.clk, .rst_n, .q_empty(empty), .q_dout, .q_pop(pop), .out_valid,
                      .out_stall, .out_token_kind, .out_token_length, .out_keyword_number,
                      .out_bool_value, .out_last_of_run);
endmodule
